// ===== design/gvie_pkg.sv =====
// ----------------------------------------------------------------------------
// gvie_pkg: shared types and constants of the group varint integer encoder
// Word layouts of both channels, configuration indexes and the command and
// status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package gvie_pkg;

  localparam int unsigned ValueW  = 32;
  localparam int unsigned CountW  = 4;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 4;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgIntLimit = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgLogging  = 2'd1;

  localparam logic [CountW-1:0] IntLimitRst = 4'd15;
  localparam logic              LoggingRst  = 1'b1;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              record_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0]        out_byte;
    logic              byte_valid;
    logic              is_flag_byte;
    logic              group_end;
    logic              record_end;
    logic [CountW-1:0] int_count;
    logic              overflow;
  } out_item_t;

  typedef enum logic [1:0] {
    EmitFlag = 2'd0,
    EmitByte = 2'd1,
    EmitMark = 2'd2
  } emit_kind_e;

  typedef struct packed {
    logic       absorb;
    logic       emit;
    emit_kind_e emit_kind;
  } cmd_t;

  typedef struct packed {
    logic enabled;
    logic flush;
    logic mark;
    logic byte_final;
    logic out_free;
  } sts_t;

  // Size code (bytes minus one) of the shortest little-endian form
  function automatic logic [1:0] len_code(input logic [ValueW-1:0] v);
    logic [1:0] c;
    if (v[31:24] != 8'h00) begin
      c = 2'd3;
    end else if (v[23:16] != 8'h00) begin
      c = 2'd2;
    end else if (v[15:8] != 8'h00) begin
      c = 2'd1;
    end else begin
      c = 2'd0;
    end
    return c;
  endfunction

endpackage

// ===== design/gvie_datapath.sv =====
// ----------------------------------------------------------------------------
// gvie_datapath: group buffer, counters and output word register
// Holds the open group, the record counters and the configuration, and
// builds each output word on command from the controller.
// ----------------------------------------------------------------------------
module gvie_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [gvie_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [gvie_pkg::CfgDatW-1:0]   cfg_wdata_i,
  input  gvie_pkg::in_item_t             in_data_i,
  input  gvie_pkg::cmd_t                 cmd_i,
  output gvie_pkg::sts_t                 sts_o,
  input  logic                           out_stall_i,
  output logic                           out_valid_o,
  output gvie_pkg::out_item_t            out_data_o
);

  logic [gvie_pkg::ValueW-1:0] vals_q [4];
  logic [2:0]                  fill_q, fill_d;
  logic [7:0]                  flag_q, flag_d;
  logic [gvie_pkg::CountW-1:0] count_q, count_d;
  logic                        ovf_q, ovf_d;
  logic                        last_q, last_d;
  logic [1:0]                  slot_q, slot_d;
  logic [1:0]                  bidx_q, bidx_d;
  logic [gvie_pkg::CountW-1:0] limit_q;
  logic                        enable_q;
  logic                        out_valid_q, out_valid_d;
  gvie_pkg::out_item_t         out_q, out_d;

  logic                        take;
  logic [2:0]                  fill_inc;
  logic [1:0]                  in_code;
  logic [gvie_pkg::ValueW-1:0] cur_val;
  logic [1:0]                  cur_code;
  logic [7:0]                  cur_byte;
  logic                        int_done;
  logic                        byte_final;
  logic                        out_free;

  assign take     = (count_q < limit_q);
  assign fill_inc = fill_q + 3'd1;
  assign in_code  = gvie_pkg::len_code(in_data_i.value);

  assign cur_val  = vals_q[slot_q];
  assign cur_code = flag_q[{slot_q, 1'b0} +: 2];
  assign int_done = (bidx_q == cur_code);
  assign byte_final = int_done && (slot_q == 2'(fill_q - 3'd1));
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    case (bidx_q)
      2'd0:    cur_byte = cur_val[7:0];
      2'd1:    cur_byte = cur_val[15:8];
      2'd2:    cur_byte = cur_val[23:16];
      default: cur_byte = cur_val[31:24];
    endcase
  end

  always_comb begin
    sts_o.enabled    = enable_q;
    sts_o.flush      = (take && (fill_inc == 3'd4)) ||
                       (in_data_i.record_last && (take || (fill_q != 3'd0)));
    sts_o.mark       = in_data_i.record_last && !sts_o.flush;
    sts_o.byte_final = byte_final;
    sts_o.out_free   = out_free;
  end

  always_comb begin
    fill_d      = fill_q;
    flag_d      = flag_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    last_d      = last_q;
    slot_d      = slot_q;
    bidx_d      = bidx_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    if (cmd_i.absorb) begin
      last_d = in_data_i.record_last;
      if (take) begin
        flag_d  = flag_q | (8'(in_code) << {fill_q[1:0], 1'b0});
        fill_d  = fill_inc;
        count_d = count_q + 4'd1;
      end else begin
        ovf_d = 1'b1;
      end
    end

    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      case (cmd_i.emit_kind)
        gvie_pkg::EmitFlag: begin
          out_d.out_byte     = flag_q;
          out_d.byte_valid   = 1'b1;
          out_d.is_flag_byte = 1'b1;
          out_d.group_end    = 1'b0;
          out_d.record_end   = 1'b0;
          out_d.int_count    = count_q;
          out_d.overflow     = 1'b0;
          slot_d = 2'd0;
          bidx_d = 2'd0;
        end
        gvie_pkg::EmitByte: begin
          out_d.out_byte     = cur_byte;
          out_d.byte_valid   = 1'b1;
          out_d.is_flag_byte = 1'b0;
          out_d.group_end    = byte_final;
          out_d.record_end   = byte_final && last_q;
          out_d.int_count    = count_q;
          out_d.overflow     = byte_final && last_q && ovf_q;
          if (int_done) begin
            slot_d = slot_q + 2'd1;
            bidx_d = 2'd0;
          end else begin
            bidx_d = bidx_q + 2'd1;
          end
          // Close the group, and the record too when it ends here
          if (byte_final) begin
            fill_d = 3'd0;
            flag_d = 8'h00;
            if (last_q) begin
              count_d = '0;
              ovf_d   = 1'b0;
            end
          end
        end
        gvie_pkg::EmitMark: begin
          out_d.out_byte     = 8'h00;
          out_d.byte_valid   = 1'b0;
          out_d.is_flag_byte = 1'b0;
          out_d.group_end    = 1'b1;
          out_d.record_end   = 1'b1;
          out_d.int_count    = count_q;
          out_d.overflow     = ovf_q;
          fill_d  = 3'd0;
          flag_d  = 8'h00;
          count_d = '0;
          ovf_d   = 1'b0;
        end
        default: begin
          out_valid_d = out_valid_q && out_stall_i;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= 3'd0;
      flag_q      <= 8'h00;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      last_q      <= 1'b0;
      slot_q      <= 2'd0;
      bidx_q      <= 2'd0;
      out_valid_q <= 1'b0;
      limit_q     <= gvie_pkg::IntLimitRst;
      enable_q    <= gvie_pkg::LoggingRst;
    end else begin
      fill_q      <= fill_d;
      flag_q      <= flag_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      last_q      <= last_d;
      slot_q      <= slot_d;
      bidx_q      <= bidx_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          gvie_pkg::CfgIntLimit: limit_q  <= cfg_wdata_i;
          gvie_pkg::CfgLogging:  enable_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
    end
  end

  // Group buffer and output word: payload only
  always_ff @(posedge clk_i) begin
    if (cmd_i.absorb && take) begin
      vals_q[fill_q[1:0]] <= in_data_i.value;
    end
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== design/gvie_ctrl.sv =====
// ----------------------------------------------------------------------------
// gvie_ctrl: sequencing of the group varint encoder
// Takes one input word at a time and steps the datapath through the flag
// byte, the value bytes or the empty-record marker.
// ----------------------------------------------------------------------------
module gvie_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  gvie_pkg::sts_t sts_i,
  output gvie_pkg::cmd_t cmd_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StFlag = 2'd1;
  localparam logic [1:0] StByte = 2'd2;
  localparam logic [1:0] StMark = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d         = state_q;
    cmd_o.absorb    = 1'b0;
    cmd_o.emit      = 1'b0;
    cmd_o.emit_kind = gvie_pkg::EmitFlag;
    case (state_q)
      StIdle: begin
        if (in_valid_i && sts_i.enabled) begin
          cmd_o.absorb = 1'b1;
          if (sts_i.flush) begin
            state_d = StFlag;
          end else if (sts_i.mark) begin
            state_d = StMark;
          end
        end
      end
      StFlag: begin
        cmd_o.emit_kind = gvie_pkg::EmitFlag;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = StByte;
        end
      end
      StByte: begin
        cmd_o.emit_kind = gvie_pkg::EmitByte;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.byte_final) begin
            state_d = StIdle;
          end
        end
      end
      StMark: begin
        cmd_o.emit_kind = gvie_pkg::EmitMark;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != StIdle);

endmodule

// ===== design/group_varint_int_encoder.sv =====
// ----------------------------------------------------------------------------
// group_varint_int_encoder: byte-wide group varint packer for 32-bit integers
// Buffers up to four integers, then emits the flag byte and the shortest
// little-endian form of each integer, one byte word per cycle unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid_i / in_stall_o / in_data_i): one integer per
//    word, with record_last closing the record. Accepted when valid is high,
//    stall is low and logging is on.
//  - Output channel (out_valid_o / out_stall_i / out_data_o): one byte word
//    per result; group_end marks the last word caused by an input word,
//    record_end the last word of a record, where overflow is also valid.
//  - Configuration (cfg_valid_i / cfg_ready_o): index 0 sets the integer
//    limit, index 1 enables logging. Always ready; write only when idle.
//  - An input word that causes no output is only absorbed in the idle state;
//    one that gives the empty-record marker also passes through StMark. One
//    that closes a group emits the flag byte and its N value bytes (up to 16)
//    through the single byte-wide output register; the flag byte passes
//    through StFlag and then the output register before it is on the output.
//  - Reset clears the group, counters and output valid flag and restores the
//    limit to 15 with logging on.
//  - A stalled output word holds; the controller waits, so the input side
//    stalls until the last word of the run in progress is in the output register.
// ----------------------------------------------------------------------------
module group_varint_int_encoder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  gvie_pkg::in_item_t           in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output gvie_pkg::out_item_t          out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [gvie_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [gvie_pkg::CfgDatW-1:0] cfg_wdata_i
);

  gvie_pkg::cmd_t cmd;
  gvie_pkg::sts_t sts;

  // Configuration writes are always taken and land on the next clock edge
  assign cfg_ready_o = 1'b1;

  gvie_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gvie_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== design/gvie_checker.sv =====
// ----------------------------------------------------------------------------
// gvie_checker: port-level checks of the group varint encoder
// Watches the output channel for word framing rules and stall behaviour.
// ----------------------------------------------------------------------------
module gvie_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input gvie_pkg::out_item_t out_data_o
);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output word changed");

  a_rec_in_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.record_end |-> out_data_o.group_end)
    else $error("record end without group end");

  a_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.byte_valid |->
      out_data_o.record_end && (out_data_o.out_byte == 8'h00) &&
      !out_data_o.is_flag_byte)
    else $error("malformed empty-record marker");

  a_ovf_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.overflow |-> out_data_o.record_end)
    else $error("overflow shown before record end");

  a_flag_leads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.is_flag_byte |->
      out_data_o.byte_valid && !out_data_o.group_end)
    else $error("flag byte ends a run");

endmodule

bind group_varint_int_encoder gvie_checker u_gvie_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
